### hw/rtl/twmn_pkg.sv
// Shared types, constants and the arctangent table for the touch wheel menu navigator.
package twmn_pkg;

    typedef struct packed {
        logic [15:0] pad1_reading;
        logic [15:0] pad2_reading;
        logic [15:0] pad3_reading;
        logic        button_level;
    } t_in_item;

    typedef struct packed {
        logic [3:0] chosen_entry;
        logic [3:0] first_shown;
        logic [1:0] move_step;
        logic       button_held;
        logic       wheel_tracking;
    } t_out_item;

    localparam int ITER_W    = 5;
    localparam int CFG_IDX_W = 3;
    localparam int ANG_W     = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_BASELINE_PAD1 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASELINE_PAD2 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASELINE_PAD3 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MENU_LENGTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VISIBLE_ROWS  = 3'd4;

    localparam logic [1:0] MOVE_NONE = 2'd0;
    localparam logic [1:0] MOVE_UP   = 2'd1;
    localparam logic [1:0] MOVE_DOWN = 2'd2;

    // angles in 1/64 degree
    localparam logic signed [15:0] DEG3   = 16'sd192;
    localparam logic signed [15:0] DEG30  = 16'sd1920;
    localparam logic signed [15:0] DEG90  = 16'sd5760;
    localparam logic signed [15:0] DEG180 = 16'sd11520;
    localparam logic signed [15:0] DEG360 = 16'sd23040;

    localparam logic signed [14:0] SUM_STEP  = 15'sd1920;
    localparam logic signed [16:0] SUM_LIMIT = 17'sd16383;

    localparam logic signed [16:0] DEV_FLOOR  = 17'sd5;
    localparam logic        [17:0] TOUCH_MIN  = 18'd10;
    // 2 * cos(30 deg) in Q10, rounded
    localparam logic        [10:0] Y_GAIN     = 11'd1774;

    typedef struct packed {
        logic              load;
        logic              dev;
        logic              vec;
        logic              rot;
        logic              ang;
        logic              dlt;
        logic              acc;
        logic              commit;
        logic [ITER_W-1:0] iter;
    } t_dp_cmd;

    typedef struct packed {
        logic skip_rot;
        logic out_busy;
    } t_dp_stat;

    function automatic logic [11:0] atan_entry(input logic [ITER_W-1:0] i);
        logic [11:0] a;
        unique case (i)
            5'd0:    a = 12'd2880;
            5'd1:    a = 12'd1700;
            5'd2:    a = 12'd898;
            5'd3:    a = 12'd456;
            5'd4:    a = 12'd229;
            5'd5:    a = 12'd115;
            5'd6:    a = 12'd57;
            5'd7:    a = 12'd29;
            5'd8:    a = 12'd14;
            5'd9:    a = 12'd7;
            5'd10:   a = 12'd4;
            5'd11:   a = 12'd2;
            5'd12:   a = 12'd1;
            default: a = 12'd0;
        endcase
        return a;
    endfunction

endpackage

### hw/rtl/twmn_ctrl.sv
// Sequencer for the touch wheel navigator: steps the datapath through one item.
module twmn_ctrl #(
    parameter int CORDIC_STEPS = 14
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  twmn_pkg::t_dp_stat i_stat,
    output twmn_pkg::t_dp_cmd  o_cmd
);
    import twmn_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DEV  = 3'd1;
    localparam logic [2:0] ST_VEC  = 3'd2;
    localparam logic [2:0] ST_ROT  = 3'd3;
    localparam logic [2:0] ST_ANG  = 3'd4;
    localparam logic [2:0] ST_DLT  = 3'd5;
    localparam logic [2:0] ST_ACC  = 3'd6;
    localparam logic [2:0] ST_UPD  = 3'd7;

    localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(CORDIC_STEPS - 1);

    logic [2:0]        r_state, n_state;
    logic [ITER_W-1:0] r_iter,  n_iter;

    always_comb begin
        n_state    = r_state;
        n_iter     = r_iter;
        o_cmd      = '0;
        o_cmd.iter = r_iter;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DEV;
                end
            end
            ST_DEV: begin
                o_cmd.dev = 1'b1;
                n_state   = ST_VEC;
            end
            ST_VEC: begin
                o_cmd.vec = 1'b1;
                n_iter    = '0;
                n_state   = i_stat.skip_rot ? ST_ANG : ST_ROT;
            end
            ST_ROT: begin
                o_cmd.rot = 1'b1;
                if (r_iter == LAST_ITER) begin
                    n_state = ST_ANG;
                end else begin
                    n_iter = r_iter + 1'b1;
                end
            end
            ST_ANG: begin
                o_cmd.ang = 1'b1;
                n_state   = ST_DLT;
            end
            ST_DLT: begin
                o_cmd.dlt = 1'b1;
                n_state   = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = ST_UPD;
            end
            ST_UPD: begin
                // hold until the output register can take the result
                if (!i_stat.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

### hw/rtl/twmn_datapath.sv
// Datapath: pad deviations, CORDIC angle, rotation tracking, menu state and result register.
module twmn_datapath #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  twmn_pkg::t_dp_cmd             i_cmd,
    output twmn_pkg::t_dp_stat            o_stat,
    input  twmn_pkg::t_in_item            i_in_data,
    input  logic                          i_cfg_we,
    input  logic [twmn_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                   i_cfg_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output twmn_pkg::t_out_item           o_out_data
);
    import twmn_pkg::*;

    // menu_length is 5 bits, so no more than 31 entries can ever be in use
    localparam int N_MAX = (MAX_ENTRIES < 31) ? MAX_ENTRIES : 31;
    localparam int IDX_W = $clog2(N_MAX);
    localparam int CW    = ((IDX_W > 5) ? IDX_W : 5) + 2;

    // configuration
    logic [15:0] r_base1, r_base2, r_base3;
    logic [4:0]  r_mlen, r_vrows;

    // wheel and menu state
    logic [ANG_W-1:0]        r_prev,  n_prev;
    logic                    r_track, n_track;
    logic signed [14:0]      r_sum,   n_sum;
    logic [IDX_W-1:0]        r_hl,    n_hl;
    logic [IDX_W-1:0]        r_wt,    n_wt;
    logic                    r_btn,   n_btn;
    logic [1:0]              n_move;

    // per-item working registers
    t_in_item           r_in;
    logic [15:0]        r_d1, r_d2, r_d3;
    logic               r_pressed, r_en, r_touched, r_heavy;
    logic signed [31:0] r_x, r_y;
    logic signed [15:0] r_z;
    logic [ANG_W-1:0]   r_angle;
    logic signed [15:0] r_delta;
    logic               r_band;
    logic signed [14:0] r_sacc;

    logic               r_out_valid;
    t_out_item          r_out;

    // ---- deviations
    logic signed [16:0] raw1, raw2, raw3;
    logic [15:0]        dev1, dev2, dev3;
    logic [17:0]        dev_sum;

    assign raw1 = $signed({1'b0, r_base1}) - $signed({1'b0, r_in.pad1_reading});
    assign raw2 = $signed({1'b0, r_base2}) - $signed({1'b0, r_in.pad2_reading});
    assign raw3 = $signed({1'b0, r_base3}) - $signed({1'b0, r_in.pad3_reading});
    assign dev1 = (raw1 < DEV_FLOOR) ? 16'd0 : raw1[15:0];
    assign dev2 = (raw2 < DEV_FLOOR) ? 16'd0 : raw2[15:0];
    assign dev3 = (raw3 < DEV_FLOOR) ? 16'd0 : raw3[15:0];
    assign dev_sum = {2'b00, dev1} + {2'b00, dev2} + {2'b00, dev3};

    // ---- vector set-up; negate before the gain multiply when x is negative
    logic signed [18:0] xd, xabs;
    logic signed [17:0] yd, ysel;
    logic               xneg;
    logic signed [29:0] yprod;

    assign xd    = $signed({2'b00, r_d1, 1'b0}) - $signed({3'b000, r_d2})
                 - $signed({3'b000, r_d3});
    assign yd    = $signed({2'b00, r_d2}) - $signed({2'b00, r_d3});
    assign xneg  = xd[18];
    assign xabs  = xneg ? -xd : xd;
    assign ysel  = xneg ? -yd : yd;
    assign yprod = 30'(ysel) * 30'($signed({1'b0, Y_GAIN}));

    // ---- one CORDIC vectoring step
    logic signed [31:0] xs, ys;
    logic signed [15:0] at;
    logic               y_pos;

    assign xs    = r_x >>> i_cmd.iter;
    assign ys    = r_y >>> i_cmd.iter;
    assign at    = $signed({4'b0000, atan_entry(i_cmd.iter)});
    assign y_pos = !r_y[31] && (r_y != 32'sd0);

    // ---- angle wrap, delta, accumulation
    logic signed [15:0] zw, draw, dwrap, dmag;
    logic signed [16:0] sum_raw;
    logic signed [14:0] sum_sat;

    assign zw = (r_z < 16'sd0) ? r_z + DEG360 :
                (r_z >= DEG360) ? r_z - DEG360 : r_z;
    assign draw  = $signed({1'b0, r_angle}) - $signed({1'b0, r_prev});
    assign dwrap = (draw > DEG180) ? draw - DEG360 :
                   (draw < -DEG180) ? draw + DEG360 : draw;
    assign dmag  = dwrap[15] ? -dwrap : dwrap;
    assign sum_raw = $signed({r_sum[14], r_sum[14], r_sum}) + $signed({r_delta[15], r_delta});
    assign sum_sat = (sum_raw > SUM_LIMIT)  ? SUM_LIMIT[14:0] :
                     (sum_raw < -SUM_LIMIT) ? -SUM_LIMIT[14:0] : sum_raw[14:0];

    // ---- menu moves
    logic [CW-1:0] mlen_c, rows_c, n_len, n_rows, h_c, w_c;
    logic [CW-1:0] hu, wu, hd, wd, hd1;
    logic          go_up, go_dn;

    assign mlen_c = {{(CW-5){1'b0}}, r_mlen};
    assign rows_c = {{(CW-5){1'b0}}, r_vrows};
    assign n_len  = (mlen_c == '0) ? CW'(1) : ((mlen_c > CW'(N_MAX)) ? CW'(N_MAX) : mlen_c);
    assign n_rows = (rows_c == '0) ? CW'(1) : rows_c;
    assign h_c    = {{(CW-IDX_W){1'b0}}, r_hl};
    assign w_c    = {{(CW-IDX_W){1'b0}}, r_wt};
    assign hd1    = h_c + CW'(1);

    always_comb begin
        // move up, wrapping to the last entry from the first or from a stale index
        if (h_c == '0 || h_c >= n_len) begin
            hu = n_len - CW'(1);
            wu = (n_len > n_rows) ? n_len - n_rows : '0;
        end else begin
            hu = h_c - CW'(1);
            wu = (hu < w_c) ? hu : w_c;
        end
        if (hd1 >= n_len) begin
            hd = '0;
            wd = '0;
        end else begin
            hd = hd1;
            wd = (hd1 >= w_c + n_rows) ? hd1 - n_rows + CW'(1) : w_c;
        end
    end

    assign go_up = (r_sacc >= SUM_STEP);
    assign go_dn = (r_sacc <= -SUM_STEP);

    always_comb begin
        n_prev  = r_prev;
        n_track = r_track;
        n_sum   = r_sum;
        n_hl    = r_hl;
        n_wt    = r_wt;
        n_btn   = r_btn;
        n_move  = MOVE_NONE;
        if (r_en) begin
            if (r_touched) begin
                if (r_heavy) begin
                    if (r_band) begin
                        n_sum = r_sacc;
                        if (go_up) begin
                            n_hl  = hu[IDX_W-1:0];
                            n_wt  = wu[IDX_W-1:0];
                            n_sum = r_sacc - SUM_STEP;
                            if (hu != h_c) begin
                                n_move = MOVE_UP;
                            end
                        end else if (go_dn) begin
                            n_hl  = hd[IDX_W-1:0];
                            n_wt  = wd[IDX_W-1:0];
                            n_sum = r_sacc + SUM_STEP;
                            if (hd != h_c) begin
                                n_move = MOVE_DOWN;
                            end
                        end
                    end
                    n_prev  = r_angle;
                    n_track = 1'b1;
                end
            end else begin
                n_track = 1'b0;
                n_sum   = '0;
            end
            n_btn = r_pressed;
        end
    end

    logic [IDX_W+3:0] hl_ext, wt_ext;
    assign hl_ext = {4'b0000, n_hl};
    assign wt_ext = {4'b0000, n_wt};

    // ---- control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base1     <= '0;
            r_base2     <= '0;
            r_base3     <= '0;
            r_mlen      <= 5'd3;
            r_vrows     <= 5'd3;
            r_prev      <= '0;
            r_track     <= 1'b0;
            r_sum       <= '0;
            r_hl        <= '0;
            r_wt        <= '0;
            r_btn       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_BASELINE_PAD1: r_base1 <= i_cfg_data;
                    CFG_BASELINE_PAD2: r_base2 <= i_cfg_data;
                    CFG_BASELINE_PAD3: r_base3 <= i_cfg_data;
                    CFG_MENU_LENGTH:   r_mlen  <= i_cfg_data[4:0];
                    CFG_VISIBLE_ROWS:  r_vrows <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (i_cmd.commit) begin
                r_prev      <= n_prev;
                r_track     <= n_track;
                r_sum       <= n_sum;
                r_hl        <= n_hl;
                r_wt        <= n_wt;
                r_btn       <= n_btn;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---- working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in_data;
        end
        if (i_cmd.dev) begin
            r_d1      <= dev1;
            r_d2      <= dev2;
            r_d3      <= dev3;
            r_pressed <= r_in.button_level;
            r_en      <= (r_base1 != '0) || (r_base2 != '0) || (r_base3 != '0);
            r_touched <= (dev1 != '0) || (dev2 != '0) || (dev3 != '0);
            r_heavy   <= (dev_sum > TOUCH_MIN);
        end
        if (i_cmd.vec) begin
            r_x <= {{3{xabs[18]}}, xabs, 10'b0};
            r_y <= {{2{yprod[29]}}, yprod};
            r_z <= xneg ? DEG180 : 16'sd0;
        end
        if (i_cmd.rot) begin
            if (y_pos) begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + at;
            end else begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - at;
            end
        end
        if (i_cmd.ang) begin
            r_angle <= zw[ANG_W-1:0];
        end
        if (i_cmd.dlt) begin
            r_delta <= dwrap;
            r_band  <= r_track && (dmag > DEG3) && (dmag < DEG90);
        end
        if (i_cmd.acc) begin
            r_sacc <= sum_sat;
        end
        if (i_cmd.commit) begin
            r_out.chosen_entry   <= hl_ext[3:0];
            r_out.first_shown    <= wt_ext[3:0];
            r_out.move_step      <= n_move;
            r_out.button_held    <= n_btn;
            r_out.wheel_tracking <= n_track;
        end
    end

    assign o_stat.skip_rot = (r_d2 == r_d3) || !(r_en && r_touched && r_heavy);
    assign o_stat.out_busy = r_out_valid && i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;

endmodule

### hw/rtl/touch_wheel_menu_navigator_core.sv
// Top level of the three-pad touch wheel menu navigator.
// Takes one pad sample at a time and returns one menu status item for each. An item
// passes through the deviation, vector set-up, CORDIC rotation, angle, delta,
// accumulation and update states after it is accepted; the rotation steps are skipped
// when no angle is needed (no baselines, no touch, a light touch or a zero vertical
// component). The CORDIC vectoring loop does one step per cycle on a single shift-add
// unit; the next item is accepted the cycle after the result is registered. The result
// register lets the next item start while the previous result is still stalled; a
// finished item waits only if that register is still full. Configuration writes are
// always ready and must be made while the block is idle.
module touch_wheel_menu_navigator_core #(
    parameter int MAX_ENTRIES  = 16,
    parameter int CORDIC_STEPS = 14
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  twmn_pkg::t_in_item             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output twmn_pkg::t_out_item            o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [twmn_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                    i_cfg_data
);
    import twmn_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    twmn_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    twmn_datapath #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTHESIS
    // one item in flight: acceptance closes the input side
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted while an item is in flight");

    // a menu move can only come from a tracked rotation
    a_move_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.move_step != MOVE_NONE)) |-> o_out_data.wheel_tracking)
        else $error("menu move reported without wheel tracking");

    // the input side only closes because an item arrived
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(i_in_valid))
        else $error("input stalled without an accepted item");
`endif

endmodule

### tb/tb_top.sv
// Self-checking testbench for the touch wheel menu navigator core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import twmn_pkg::*;

    localparam int    CORDIC_STEPS   = 14;
    localparam int    MAX_ENTRIES    = 16;
    localparam int    RANDOM_ITEMS   = 600;
    localparam int    WATCHDOG_LIMIT = 3000;
    localparam int    SETTLE_CYCLES  = CORDIC_STEPS + 10;
    localparam real   PI             = 3.14159265358979;

    // angles in 1/64 degree
    localparam int ANG_3   = 192;
    localparam int ANG_30  = 1920;
    localparam int ANG_90  = 5760;
    localparam int ANG_180 = 11520;
    localparam int ANG_360 = 23040;
    localparam int ROT_CAP = 16383;

    localparam logic [15:0] FULL  = 16'hFFFF;
    localparam logic [15:0] PRESS = 16'hFC17;   // 1000 counts below full scale

    localparam t_out_item ALL_CLEAR = '0;

    typedef enum logic { ROW_ITEM, ROW_CFG } t_row_kind;

    typedef struct {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [15:0]            reg_val;
        t_in_item               sample;
        bit                     typed;
        t_out_item              want;
    } t_plan_row;

    typedef enum int { STALL_NONE, STALL_RANDOM, STALL_LONG, STALL_ALT } t_stall_mode;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in_item             i_in_data;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out_data;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [15:0]          i_cfg_data;

    touch_wheel_menu_navigator_core #(
        .MAX_ENTRIES  (MAX_ENTRIES),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor copy of registers and state
    logic [15:0] base_p1, base_p2, base_p3;
    logic [4:0]  menu_len, rows_shown;
    int          last_angle;
    bit          tracking;
    int          rot_acc;
    int          highlight;
    int          win_top;
    bit          btn_latch;

    int atan_lut [0:13] = '{2880, 1700, 898, 456, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

    t_out_item   status_q [$];
    int          n_errors = 0;
    int          quiet_cycles = 0;
    int          burst_left = 0;
    int          random_done = 0;
    t_plan_row   plan [$];

    function automatic int wheel_angle_of(int d1, int d2, int d3);
        longint x, y, xs, ys;
        int     z;
        x = 1024 * (2 * longint'(d1) - d2 - d3);
        y = 1774 * (longint'(d2) - d3);
        z = 0;
        if (y == 0)
            return (x < 0) ? ANG_180 : 0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = ANG_180;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x += ys;
                y -= xs;
                z += atan_lut[i];
            end else begin
                x -= ys;
                y += xs;
                z -= atan_lut[i];
            end
        end
        if (z < 0)
            z += ANG_360;
        if (z >= ANG_360)
            z -= ANG_360;
        return z;
    endfunction

    // advances the predicted state by one sample and returns the status it causes
    function automatic t_out_item menu_status_after(t_in_item s);
        int        d1, d2, d3, ang, delta, mag, n, v, was;
        logic [1:0] mv;
        t_out_item r;
        mv = MOVE_NONE;
        if (base_p1 != 0 || base_p2 != 0 || base_p3 != 0) begin
            d1 = int'(base_p1) - int'(s.pad1_reading);
            d2 = int'(base_p2) - int'(s.pad2_reading);
            d3 = int'(base_p3) - int'(s.pad3_reading);
            if (d1 < 5) d1 = 0;
            if (d2 < 5) d2 = 0;
            if (d3 < 5) d3 = 0;
            if (d1 > 0 || d2 > 0 || d3 > 0) begin
                if (d1 + d2 + d3 > 10) begin
                    ang = wheel_angle_of(d1, d2, d3);
                    if (tracking) begin
                        delta = ang - last_angle;
                        if (delta > ANG_180)  delta -= ANG_360;
                        if (delta < -ANG_180) delta += ANG_360;
                        mag = (delta < 0) ? -delta : delta;
                        if (mag > ANG_3 && mag < ANG_90) begin
                            n = (menu_len < 1) ? 1 : (menu_len > MAX_ENTRIES) ? MAX_ENTRIES
                                                                              : menu_len;
                            v = (rows_shown < 1) ? 1 : rows_shown;
                            was = highlight;
                            rot_acc += delta;
                            if (rot_acc > ROT_CAP)  rot_acc = ROT_CAP;
                            if (rot_acc < -ROT_CAP) rot_acc = -ROT_CAP;
                            if (rot_acc >= ANG_30) begin
                                // up, wrapping to the last entry (also from a stale index)
                                if (highlight == 0 || highlight >= n) begin
                                    highlight = n - 1;
                                    win_top = (n > v) ? n - v : 0;
                                end else begin
                                    highlight--;
                                    if (highlight < win_top)
                                        win_top = highlight;
                                end
                                rot_acc -= ANG_30;
                                if (highlight != was) mv = MOVE_UP;
                            end else if (rot_acc <= -ANG_30) begin
                                highlight++;
                                if (highlight >= n) begin
                                    highlight = 0;
                                    win_top = 0;
                                end else if (highlight >= win_top + v) begin
                                    win_top = highlight - v + 1;
                                end
                                rot_acc += ANG_30;
                                if (highlight != was) mv = MOVE_DOWN;
                            end
                        end
                    end
                    last_angle = ang;
                    tracking = 1'b1;
                end
            end else begin
                tracking = 1'b0;
                rot_acc = 0;
            end
            btn_latch = s.button_level;
        end
        r.chosen_entry   = highlight[3:0];
        r.first_shown    = win_top[3:0];
        r.move_step      = mv;
        r.button_held    = btn_latch;
        r.wheel_tracking = tracking;
        return r;
    endfunction

    // readings for a finger at theta degrees, pads at 0, 120 and 240 degrees
    function automatic t_in_item touch_at(real theta, int amp, int ctr, bit btn);
        logic [15:0] bl [3];
        logic [15:0] rd [3];
        int          d;
        t_in_item    s;
        bl = '{base_p1, base_p2, base_p3};
        for (int k = 0; k < 3; k++) begin
            d = $rtoi(real'(ctr) + real'(amp) * $cos((theta - 120.0 * k) * PI / 180.0) + 0.5);
            rd[k] = (d > int'(bl[k])) ? 16'd0 : 16'(int'(bl[k]) - d);
        end
        s.pad1_reading = rd[0];
        s.pad2_reading = rd[1];
        s.pad3_reading = rd[2];
        s.button_level = btn;
        return s;
    endfunction

    function automatic t_plan_row smp(logic [15:0] p1, logic [15:0] p2, logic [15:0] p3,
                                      logic b);
        t_plan_row r;
        r.kind    = ROW_ITEM;
        r.reg_idx = '0;
        r.reg_val = '0;
        r.sample  = '{p1, p2, p3, b};
        r.typed   = 1'b0;
        r.want    = '0;
        return r;
    endfunction

    function automatic t_plan_row smp_want(logic [15:0] p1, logic [15:0] p2, logic [15:0] p3,
                                           logic b, t_out_item w);
        t_plan_row r;
        r       = smp(p1, p2, p3, b);
        r.typed = 1'b1;
        r.want  = w;
        return r;
    endfunction

    function automatic t_plan_row wr(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        t_plan_row r;
        r         = smp('0, '0, '0, 1'b0);
        r.kind    = ROW_CFG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic logic [15:0] pick_len();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'd16;
            3:       return 16'($urandom_range(17, 31));
            default: return 16'($urandom_range(1, 16));
        endcase
    endfunction

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_BASELINE_PAD1: base_p1    = val;
            CFG_BASELINE_PAD2: base_p2    = val;
            CFG_BASELINE_PAD3: base_p3    = val;
            CFG_MENU_LENGTH:   menu_len   = val[4:0];
            CFG_VISIBLE_ROWS:  rows_shown = val[4:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_item(t_in_item s, bit typed, t_out_item want);
        int        gap;
        t_out_item got;
        // bursts of back-to-back items separated by random gaps
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else begin
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 12);
            gap = $urandom_range(1, 40);
        end
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= s;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        got = menu_status_after(s);
        status_q.push_back(typed ? want : got);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // receiver stall pattern
    t_stall_mode stall_mode = STALL_NONE;
    int          stall_left = 0;
    int          stall_tick = 0;

    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_left = $urandom_range(150, 500);
        end else begin
            stall_left--;
        end
        stall_tick++;
        case (stall_mode)
            STALL_NONE:   i_out_stall <= 1'b0;
            STALL_RANDOM: i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_LONG:   i_out_stall <= ((stall_tick % 37) < 25);
            default:      i_out_stall <= (stall_tick % 2 == 1);
        endcase
    end

    task automatic flag(string field, int want, int got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, field, want, got);
        n_errors++;
    endtask

    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (status_q.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual %h", $realtime,
                         o_out_data);
                n_errors++;
            end else begin
                e = status_q.pop_front();
                if (o_out_data.chosen_entry !== e.chosen_entry)
                    flag("chosen_entry", e.chosen_entry, o_out_data.chosen_entry);
                if (o_out_data.first_shown !== e.first_shown)
                    flag("first_shown", e.first_shown, o_out_data.first_shown);
                if (o_out_data.move_step !== e.move_step)
                    flag("move_step", e.move_step, o_out_data.move_step);
                if (o_out_data.button_held !== e.button_held)
                    flag("button_held", e.button_held, o_out_data.button_held);
                if (o_out_data.wheel_tracking !== e.wheel_tracking)
                    flag("wheel_tracking", e.wheel_tracking, o_out_data.wheel_tracking);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid === 1'b1 && o_in_stall === 1'b0) ||
            (o_out_valid === 1'b1 && i_out_stall === 1'b0) ||
            (i_cfg_valid === 1'b1 && o_cfg_ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_row_kind prev_kind;
        int        phase_no, phase_len, n_here, steps, dir, amp, ctr, pick, half;
        real       theta;
        bit        btn;
        t_in_item  s;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        base_p1     = '0;
        base_p2     = '0;
        base_p3     = '0;
        menu_len    = 5'd3;
        rows_shown  = 5'd3;
        last_angle  = 0;
        tracking    = 1'b0;
        rot_acc     = 0;
        highlight   = 0;
        win_top     = 0;
        btn_latch   = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // no baselines: nothing moves, the button latch included
        plan.push_back(smp_want(16'h0000, 16'h0000, 16'h0000, 1'b0, ALL_CLEAR));
        plan.push_back(smp_want(FULL, FULL, FULL, 1'b1, ALL_CLEAR));
        plan.push_back(wr(CFG_BASELINE_PAD1, FULL));
        plan.push_back(wr(CFG_BASELINE_PAD2, FULL));
        plan.push_back(wr(CFG_BASELINE_PAD3, FULL));
        plan.push_back(smp_want(FULL, FULL, FULL, 1'b1,
                                t_out_item'{4'd0, 4'd0, MOVE_NONE, 1'b1, 1'b0}));
        // all pads fully pressed: zero vector, angle 0, starts tracking
        plan.push_back(smp_want(16'h0000, 16'h0000, 16'h0000, 1'b0,
                                t_out_item'{4'd0, 4'd0, MOVE_NONE, 1'b0, 1'b1}));
        // deviation of 4 is floored to no touch: release
        plan.push_back(smp_want(16'hFFFB, FULL, FULL, 1'b0, ALL_CLEAR));
        // light touch, sum of exactly 10
        plan.push_back(smp_want(16'hFFFA, 16'hFFFA, FULL, 1'b1,
                                t_out_item'{4'd0, 4'd0, MOVE_NONE, 1'b1, 1'b0}));
        plan.push_back(smp(FULL, PRESS, PRESS, 1'b0));     // 180, zero vertical component with X < 0
        plan.push_back(smp(PRESS, FULL, FULL, 1'b0));      // 0, half-turn jump ignored
        plan.push_back(smp(PRESS, PRESS, FULL, 1'b1));     // 60 degree steps upwards
        plan.push_back(smp(FULL, PRESS, FULL, 1'b1));
        plan.push_back(smp(FULL, PRESS, PRESS, 1'b0));
        plan.push_back(smp(FULL, FULL, PRESS, 1'b0));
        plan.push_back(smp(PRESS, FULL, PRESS, 1'b1));
        plan.push_back(smp(PRESS, FULL, FULL, 1'b0));
        plan.push_back(wr(CFG_MENU_LENGTH, 16'd16));
        plan.push_back(wr(CFG_VISIBLE_ROWS, 16'd1));
        plan.push_back(smp(PRESS, FULL, PRESS, 1'b0));     // and downwards
        plan.push_back(smp(FULL, FULL, PRESS, 1'b1));
        plan.push_back(smp(FULL, PRESS, PRESS, 1'b0));
        // lengths of zero clamp to one entry; highlight now stale
        plan.push_back(wr(CFG_MENU_LENGTH, 16'd0));
        plan.push_back(wr(CFG_VISIBLE_ROWS, 16'd0));
        plan.push_back(smp(FULL, PRESS, FULL, 1'b0));
        plan.push_back(smp(PRESS, PRESS, FULL, 1'b0));
        plan.push_back(wr(CFG_MENU_LENGTH, 16'd31));
        plan.push_back(wr(CFG_VISIBLE_ROWS, 16'd31));
        plan.push_back(smp(PRESS, FULL, FULL, 1'b1));
        plan.push_back(smp(PRESS, FULL, PRESS, 1'b1));

        prev_kind = ROW_CFG;
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                if (prev_kind == ROW_ITEM)
                    drain();
                cfg_write(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                send_item(plan[i].sample, plan[i].typed, plan[i].want);
            end
            prev_kind = plan[i].kind;
        end

        phase_no = 0;
        btn = 1'b0;
        while (random_done < RANDOM_ITEMS) begin
            drain();
            pick = $urandom_range(0, 15);
            if (pick == 0) begin
                cfg_write(CFG_BASELINE_PAD1, 16'd0);
                cfg_write(CFG_BASELINE_PAD2, 16'd0);
                cfg_write(CFG_BASELINE_PAD3, 16'd0);
            end else if (pick == 1) begin
                cfg_write(CFG_BASELINE_PAD1, FULL);
                cfg_write(CFG_BASELINE_PAD2, FULL);
                cfg_write(CFG_BASELINE_PAD3, FULL);
            end else if (pick == 2) begin
                // only one or two pads calibrated
                cfg_write(CFG_BASELINE_PAD1, $urandom_range(0, 1) ? 16'($urandom) : 16'd0);
                cfg_write(CFG_BASELINE_PAD2, 16'd0);
                cfg_write(CFG_BASELINE_PAD3, 16'($urandom_range(1, 65535)));
            end else begin
                cfg_write(CFG_BASELINE_PAD1, 16'($urandom_range(8000, 65535)));
                cfg_write(CFG_BASELINE_PAD2, 16'($urandom_range(8000, 65535)));
                cfg_write(CFG_BASELINE_PAD3, 16'($urandom_range(8000, 65535)));
            end
            cfg_write(CFG_MENU_LENGTH, pick_len());
            cfg_write(CFG_VISIBLE_ROWS, pick_len());

            phase_len = $urandom_range(40, 90);
            half = phase_len / 2;
            n_here = 0;
            while (n_here < phase_len) begin
                pick = $urandom_range(0, 11);
                if (pick == 0) begin
                    s = t_in_item'({$urandom, $urandom});
                    send_item(s, 1'b0, '0);
                    n_here++;
                end else if (pick == 1) begin
                    // lift off: readings at or above the baselines
                    s.pad1_reading = 16'(base_p1 + $urandom_range(0, 65535 - base_p1));
                    s.pad2_reading = 16'(base_p2 + $urandom_range(0, 65535 - base_p2));
                    s.pad3_reading = 16'(base_p3 + $urandom_range(0, 65535 - base_p3));
                    s.button_level = btn;
                    send_item(s, 1'b0, '0);
                    n_here++;
                end else if (pick == 2) begin
                    // near the touch threshold
                    s.pad1_reading = 16'(int'(base_p1) - $urandom_range(0, 6));
                    s.pad2_reading = 16'(int'(base_p2) - $urandom_range(0, 6));
                    s.pad3_reading = 16'(int'(base_p3) - $urandom_range(0, 6));
                    s.button_level = 1'($urandom_range(0, 1));
                    send_item(s, 1'b0, '0);
                    n_here++;
                end else begin
                    // a stroke round the wheel
                    amp   = $urandom_range(20, 2000);
                    ctr   = amp + 5 + $urandom_range(0, 1000);
                    theta = real'($urandom_range(0, 359));
                    dir   = $urandom_range(0, 1) ? 1 : -1;
                    steps = $urandom_range(3, 24);
                    for (int k = 0; k < steps; k++) begin
                        if ($urandom_range(0, 7) == 0)
                            btn = !btn;
                        if ($urandom_range(0, 9) == 0)
                            theta += real'($urandom_range(0, 360)) - 180.0;
                        else
                            theta += dir * real'($urandom_range(2, 70));
                        send_item(touch_at(theta, amp, ctr, btn), 1'b0, '0);
                    end
                    n_here += steps;
                    if (phase_no % 3 == 1 && n_here > half && n_here - steps <= half)
                        drain();
                end
            end
            random_done += n_here;
            phase_no++;
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (n_errors == 0 && status_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### sim.f
hw/rtl/twmn_pkg.sv
hw/rtl/twmn_ctrl.sv
hw/rtl/twmn_datapath.sv
hw/rtl/touch_wheel_menu_navigator_core.sv
tb/tb_top.sv
